@@ sv/buc_pkg.sv @@
package buc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int VEL_W         = 24;
    localparam int RATIO_W       = 32;

    localparam int OP_W          = VEL_W + 1;
    localparam int PROD_W        = 2 * OP_W;
    localparam int FLUX2_W       = PROD_W + 1;
    localparam int FM_W          = FLUX2_W - FRACTION_BITS - 1;
    localparam int FM_LO_W       = 24;
    localparam int FM_HI_W       = FM_W - FM_LO_W;
    localparam int PL_W          = FM_LO_W + RATIO_W;
    localparam int PH_W          = FM_HI_W + RATIO_W;
    localparam int FULL_W        = FM_W + RATIO_W;
    localparam int QUO_W         = FULL_W - FRACTION_BITS;
    localparam int DELTA_CAP_LOG = 25;
    localparam int DELTA_W       = DELTA_CAP_LOG + 1;
    localparam int DIFF_W        = DELTA_W + 1;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [OP_W-1:0]  op_a;
        logic signed [OP_W-1:0]  op_b;
        logic signed [OP_W-1:0]  op_c;
        logic signed [OP_W-1:0]  op_d;
        logic signed [VEL_W-1:0] center;
        logic [RATIO_W-1:0]      ratio;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ sv/burgers_upwind_cell_update.sv @@
// Results lag the input by one cell: a cell's job enters the queue with the transfer that
// brings its right neighbor; a last cell's own job enters with its own transfer, or after its
// left neighbor's job when it follows other cells.
// Throughput: one cell per cycle through the six-stage multiply pipeline while o_stall and
// i_stall are low; a last cell after other cells raises o_stall while the front pushes its two
// jobs one at a time. Reset clears the cell window, the job queue and all valid flags.
module burgers_upwind_cell_update import buc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VEL_W-1:0] i_velocity,
    input  logic [RATIO_W-1:0]      i_step_ratio,
    input  logic                    i_last_cell,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VEL_W-1:0] o_new_velocity,
    output logic                    o_sweep_end,
    output logic                    o_saturated
);

    logic          q_push;
    logic          q_pop;
    t_job          q_in_job;
    t_job          q_head;
    t_queue_status q_status;

    buc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_velocity   (i_velocity),
        .i_step_ratio (i_step_ratio),
        .i_last_cell  (i_last_cell),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_job        (q_in_job)
    );

    buc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (q_in_job),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    buc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_q_status     (q_status),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_new_velocity (o_new_velocity),
        .o_sweep_end    (o_sweep_end),
        .o_saturated    (o_saturated)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("job queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("job queue read while empty");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

endmodule

@@ sv/buc_front.sv @@
module buc_front import buc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VEL_W-1:0] i_velocity,
    input  logic [RATIO_W-1:0]      i_step_ratio,
    input  logic                    i_last_cell,
    input  t_queue_status           i_q_status,
    output logic                    o_push,
    output t_job                    o_job
);

    logic signed [VEL_W-1:0] r_left;
    logic signed [VEL_W-1:0] r_center;
    logic [RATIO_W-1:0]      r_ratio;
    logic [1:0]              r_seen;
    logic                    r_pend;
    t_job                    r_pend_job;

    logic signed [VEL_W-1:0] n_left;
    logic signed [VEL_W-1:0] n_center;
    logic [RATIO_W-1:0]      n_ratio;
    logic [1:0]              n_seen;
    logic                    n_pend;

    logic                    accept;
    logic                    has_center;
    logic                    has_left;
    logic signed [OP_W-1:0]  vl;
    logic signed [OP_W-1:0]  vc;
    logic signed [OP_W-1:0]  vr;
    logic signed [OP_W-1:0]  sum_l;
    logic signed [OP_W-1:0]  sum_r;
    logic signed [OP_W-1:0]  diff_l;
    logic signed [OP_W-1:0]  diff_r;
    t_job                    job_mid;
    t_job                    job_end;

    assign accept     = i_valid && !r_pend && !i_q_status.full;
    assign has_center = (r_seen != 2'd0);
    assign has_left   = (r_seen >= 2'd2);
    assign o_stall    = r_pend || i_q_status.full;

    assign vl     = {r_left[VEL_W-1], r_left};
    assign vc     = {r_center[VEL_W-1], r_center};
    assign vr     = {i_velocity[VEL_W-1], i_velocity};
    assign sum_l  = vc + vl;
    assign sum_r  = vc + vr;
    assign diff_l = vc - vl;
    assign diff_r = vr - vc;

    always_comb begin
        job_mid        = '0;
        job_mid.center = r_center;
        job_mid.ratio  = r_ratio;
        job_mid.last   = 1'b0;
        if (has_left) begin
            if (vl < 0 && vc > 0) begin
                job_mid.op_a = vc;
                job_mid.op_b = diff_l;
            end else if (vc < 0 && vr > 0) begin
                job_mid.op_a = vc;
                job_mid.op_b = diff_r;
            end else begin
                job_mid.op_a = (sum_l < 0) ? '0 : sum_l;
                job_mid.op_b = diff_l;
                job_mid.op_c = (sum_r > 0) ? '0 : sum_r;
                job_mid.op_d = diff_r;
            end
        end
    end

    always_comb begin
        job_end        = '0;
        job_end.center = i_velocity;
        job_end.ratio  = i_step_ratio;
        job_end.last   = 1'b1;
    end

    always_comb begin
        o_push = 1'b0;
        o_job  = job_end;
        if (r_pend) begin
            o_push = !i_q_status.full;
            o_job  = r_pend_job;
        end else if (accept) begin
            o_push = has_center || i_last_cell;
            o_job  = has_center ? job_mid : job_end;
        end
    end

    always_comb begin
        n_left   = r_left;
        n_center = r_center;
        n_ratio  = r_ratio;
        n_seen   = r_seen;
        n_pend   = r_pend;
        if (r_pend && !i_q_status.full) begin
            n_pend = 1'b0;
        end
        if (accept) begin
            if (i_last_cell) begin
                n_left   = '0;
                n_center = '0;
                n_ratio  = '0;
                n_seen   = 2'd0;
                n_pend   = has_center;
            end else begin
                n_left   = r_center;
                n_center = i_velocity;
                n_ratio  = i_step_ratio;
                n_seen   = has_left ? 2'd2 : r_seen + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_center <= '0;
            r_ratio  <= '0;
            r_seen   <= 2'd0;
            r_pend   <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_center <= n_center;
            r_ratio  <= n_ratio;
            r_seen   <= n_seen;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_job <= job_end;
        end
    end

endmodule

@@ sv/buc_queue.sv @@
module buc_queue import buc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_status
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic [QPTR_W:0]   n_count;

    assign o_status.full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ sv/buc_back.sv @@
module buc_back import buc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_job                    i_head,
    input  t_queue_status           i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VEL_W-1:0] o_new_velocity,
    output logic                    o_sweep_end,
    output logic                    o_saturated
);

    localparam logic [FLUX2_W-1:0] ROUND_ADD =
        FLUX2_W'((64'd1 << (FRACTION_BITS + 1)) - 64'd1);
    localparam logic [QUO_W-1:0] QUO_CAP = QUO_W'(1) << DELTA_CAP_LOG;
    localparam logic signed [DIFF_W-1:0] DIFF_MAX = DIFF_W'((64'd1 << (VEL_W - 1)) - 64'd1);
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = ~DIFF_MAX;

    logic                     en;

    logic [6:1]               r_v;
    logic [5:1]               r_last;
    logic signed [VEL_W-1:0]  r_vc [1:5];
    logic [RATIO_W-1:0]       r_ratio1;
    logic [RATIO_W-1:0]       r_ratio2;
    logic signed [PROD_W-1:0] r_p1a;
    logic signed [PROD_W-1:0] r_p1b;
    logic [FM_W-1:0]          r_fm2;
    logic [5:2]               r_neg;
    logic [PL_W-1:0]          r_pl3;
    logic [PH_W-1:0]          r_ph3;
    logic [FULL_W-1:0]        r_full4;
    logic [DELTA_W-1:0]       r_q5;
    logic signed [VEL_W-1:0]  r_nv6;
    logic                     r_last6;
    logic                     r_sat6;

    logic signed [FLUX2_W-1:0] flux2;
    logic                      flux_neg;
    logic [FLUX2_W-1:0]        flux_mag;
    logic [FLUX2_W-1:0]        flux_rnd;
    logic [QUO_W-1:0]          quo;
    logic                      quo_rem;
    logic [QUO_W-1:0]          quo_adj;
    logic signed [DIFF_W-1:0]  vc_ext;
    logic signed [DIFF_W-1:0]  q_ext;
    logic signed [DIFF_W-1:0]  diff;

    assign en    = !r_v[6] || !i_stall;
    assign o_pop = en && !i_q_status.empty;

    assign flux2    = FLUX2_W'(r_p1a) + FLUX2_W'(r_p1b);
    assign flux_neg = flux2[FLUX2_W-1];
    assign flux_mag = flux_neg ? FLUX2_W'(-flux2) : FLUX2_W'(flux2);
    assign flux_rnd = flux_mag + (flux_neg ? ROUND_ADD : '0);

    assign quo     = r_full4[FULL_W-1:FRACTION_BITS];
    assign quo_rem = |r_full4[FRACTION_BITS-1:0];
    assign quo_adj = quo + QUO_W'(r_neg[4] && quo_rem);

    assign vc_ext = {{(DIFF_W - VEL_W){r_vc[5][VEL_W-1]}}, r_vc[5]};
    assign q_ext  = {1'b0, r_q5};
    assign diff   = r_neg[5] ? vc_ext + q_ext : vc_ext - q_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:1], !i_q_status.empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1a    <= PROD_W'(i_head.op_a) * PROD_W'(i_head.op_b);
            r_p1b    <= PROD_W'(i_head.op_c) * PROD_W'(i_head.op_d);
            r_vc[1]  <= i_head.center;
            r_ratio1 <= i_head.ratio;
            r_last[1] <= i_head.last;

            r_fm2    <= flux_rnd[FLUX2_W-1:FRACTION_BITS+1];
            r_neg[2] <= flux_neg;
            r_vc[2]  <= r_vc[1];
            r_ratio2 <= r_ratio1;
            r_last[2] <= r_last[1];

            r_pl3    <= PL_W'(r_fm2[FM_LO_W-1:0]) * PL_W'(r_ratio2);
            r_ph3    <= PH_W'(r_fm2[FM_W-1:FM_LO_W]) * PH_W'(r_ratio2);
            r_neg[3] <= r_neg[2];
            r_vc[3]  <= r_vc[2];
            r_last[3] <= r_last[2];

            r_full4  <= {r_ph3, {FM_LO_W{1'b0}}} + FULL_W'(r_pl3);
            r_neg[4] <= r_neg[3];
            r_vc[4]  <= r_vc[3];
            r_last[4] <= r_last[3];

            r_q5     <= (quo_adj > QUO_CAP) ? DELTA_W'(QUO_CAP) : quo_adj[DELTA_W-1:0];
            r_neg[5] <= r_neg[4];
            r_vc[5]  <= r_vc[4];
            r_last[5] <= r_last[4];

            if (diff > DIFF_MAX) begin
                r_nv6  <= DIFF_MAX[VEL_W-1:0];
                r_sat6 <= 1'b1;
            end else if (diff < DIFF_MIN) begin
                r_nv6  <= DIFF_MIN[VEL_W-1:0];
                r_sat6 <= 1'b1;
            end else begin
                r_nv6  <= diff[VEL_W-1:0];
                r_sat6 <= 1'b0;
            end
            r_last6 <= r_last[5];
        end
    end

    assign o_valid        = r_v[6];
    assign o_new_velocity = r_nv6;
    assign o_sweep_end    = r_last6;
    assign o_saturated    = r_sat6;

endmodule
